FILE: sv/url_field_splitter_defines.svh
// Assertion macros for the URL field splitter.
// Used by the top level; assumes clk_i and rst_ni are in scope.
`ifndef URL_FIELD_SPLITTER_DEFINES_SVH
`define URL_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("url_field_splitter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("url_field_splitter: next-cycle check failed");

`endif

FILE: sv/ufs_pkg.sv
// Package for the URL field splitter: parse modes, field kinds and the
// separator characters. No dependencies.
`default_nettype none

package ufs_pkg;

  // Parse modes, one-hot.
  typedef enum logic [6:0] {
    MODE_BEGIN        = 7'b0000001,
    MODE_SCHEME       = 7'b0000010,
    MODE_SCHEME_END   = 7'b0000100,
    MODE_HOST_OR_PATH = 7'b0001000,
    MODE_HOST         = 7'b0010000,
    MODE_PORT         = 7'b0100000,
    MODE_DONE         = 7'b1000000
  } parse_mode_e;

  // Field kinds as they appear on the result channel.
  typedef enum logic [2:0] {
    KIND_SCHEME = 3'd0,
    KIND_USER   = 3'd1,
    KIND_PASS   = 3'd2,
    KIND_HOST   = 3'd3,
    KIND_PORT   = 3'd4,
    KIND_PATH   = 3'd5,
    KIND_ROOT   = 3'd6
  } field_kind_e;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_AT    = 8'h40;

  // Most results one character can cause.
  localparam int unsigned MAX_RESULTS = 4;

endpackage

`default_nettype wire

FILE: sv/ufs_if.sv
// Handshake channels of the URL field splitter: the character request
// channel and the field result channel. No dependencies.
`default_nettype none

interface ufs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       url_end;

  modport source (output valid, output char_code, output url_end, input ready);
  modport sink   (input valid, input char_code, input url_end, output ready);
endinterface

interface ufs_field_if #(
  parameter int unsigned POS_W = 13
);
  logic             valid;
  logic             ready;
  logic [2:0]       field_kind;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] end_pos;
  logic             run_last;

  modport source (output valid, output field_kind, output first_pos, output end_pos,
                  output run_last, input ready);
  modport sink   (input valid, input field_kind, input first_pos, input end_pos,
                  input run_last, output ready);
endinterface

`default_nettype wire

FILE: sv/url_field_splitter.sv
// URL field splitter top level: parser state, result bundle and checks.
// Depends on ufs_pkg, ufs_if.sv and url_field_splitter_defines.svh.
`default_nettype none

`include "url_field_splitter_defines.svh"

// The block takes a URL one character per request, with url_end set on the
// last character, and returns field assignments (scheme, username, password,
// host, port, path range or default root path) as kind plus a position range
// [first_pos, end_pos). A later assignment of the same kind overrides an
// earlier one, and the consumer applies them in order. Each character is held
// in an input register; a short block of compares and a mode update turns it
// into zero to four results, which are loaded together into a result bundle
// register and then leave one per cycle while the output is ready, run_last
// marking the last result of each character. The input accepts one character
// per cycle as long as each character causes at most one result and the
// output is ready; a character that causes several results holds the result
// port until all have left, and the input register keeps taking one more
// character meanwhile. The input ready depends combinationally on the output
// ready through the bundle's emptying. Positions saturate at MAX_LEN, so port
// positions are $clog2(MAX_LEN+1) bits wide; the position count returns to
// zero after every URL.
module url_field_splitter
  import ufs_pkg::*;
#(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  ufs_char_if.sink         in_i,
  ufs_field_if.source      out_o
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);
  localparam int unsigned CntW = $clog2(MAX_RESULTS + 1);

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    field_kind_e kind;
    pos_t        first;
    pos_t        last_pos;
  } result_t;

  // Increment that saturates at MAX_LEN; values never exceed MAX_LEN.
  function automatic pos_t sat_inc(pos_t x);
    return (x == MaxPos) ? x : x + 1'b1;
  endfunction

  function automatic result_t mk_result(field_kind_e k, pos_t a, pos_t b);
    result_t r;
    r.kind     = k;
    r.first    = a;
    r.last_pos = b;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Input register.
  logic       in_v_q;
  logic [7:0] char_q;
  logic       end_q;

  // Parser state.
  parse_mode_e mode_q, mode_d;
  pos_t        pos_q, pos_d;
  pos_t        mark_q, mark_d;
  pos_t        host_begin_q, host_begin_d;
  pos_t        host_finish_q, host_finish_d;
  pos_t        path_begin_q, path_begin_d;

  // Result bundle: entry 0 is the one on the port.
  result_t          res_q [MAX_RESULTS];
  result_t          res_new [MAX_RESULTS];
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_new;

  logic out_fire;
  logic bundle_free;
  logic proc;

  assign out_fire    = out_o.valid && out_o.ready;
  assign bundle_free = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_fire);
  assign proc        = in_v_q && bundle_free;
  assign in_i.ready  = !in_v_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_code;
      end_q  <= in_i.url_end;
    end
  end

  // Per-character step. The step itself causes at most two results and the
  // end of the URL at most two more.
  result_t    step_r [2];
  result_t    end_r [2];
  logic [1:0] ns;
  logic [1:0] ne;
  pos_t       start;
  pos_t       start_e;
  pos_t       len;

  always_comb begin
    mode_d        = mode_q;
    mark_d        = mark_q;
    host_begin_d  = host_begin_q;
    host_finish_d = host_finish_q;
    path_begin_d  = path_begin_q;
    start         = sat_inc(mark_q);
    ns            = 2'd0;
    step_r[0]     = mk_result(KIND_ROOT, '0, '0);
    step_r[1]     = mk_result(KIND_ROOT, '0, '0);

    case (mode_q)
      MODE_BEGIN: begin
        if (char_q == CHAR_SLASH) begin
          mode_d = MODE_HOST_OR_PATH;
        end else if (char_q == CHAR_COLON) begin
          mode_d = MODE_SCHEME_END;
        end else if (is_letter(char_q)) begin
          mode_d = MODE_SCHEME;
        end
      end
      MODE_SCHEME: begin
        if (char_q == CHAR_COLON) begin
          mode_d = MODE_SCHEME_END;
        end
      end
      MODE_SCHEME_END: begin
        // The scheme ends just before the colon.
        step_r[0] = mk_result(KIND_SCHEME, '0, (pos_q == '0) ? '0 : pos_q - 1'b1);
        ns        = 2'd1;
        if (char_q == CHAR_SLASH) begin
          mode_d = MODE_HOST_OR_PATH;
        end
      end
      MODE_HOST_OR_PATH: begin
        if (char_q == CHAR_SLASH) begin
          mode_d = MODE_HOST;
          mark_d = pos_q;
        end else begin
          path_begin_d = pos_q;
          mode_d       = MODE_DONE;
        end
      end
      MODE_HOST: begin
        if (char_q == CHAR_COLON) begin
          step_r[0]     = mk_result(KIND_HOST, start, pos_q);
          ns            = 2'd1;
          host_begin_d  = start;
          host_finish_d = pos_q;
          mode_d        = MODE_PORT;
          mark_d        = pos_q;
        end else if (char_q == CHAR_SLASH) begin
          step_r[0]    = mk_result(KIND_HOST, start, pos_q);
          ns           = 2'd1;
          path_begin_d = pos_q;
          mode_d       = MODE_DONE;
        end else if (char_q == CHAR_AT) begin
          step_r[0] = mk_result(KIND_USER, start, pos_q);
          ns        = 2'd1;
          mark_d    = pos_q;
        end
      end
      MODE_PORT: begin
        if (char_q == CHAR_SLASH) begin
          step_r[0]    = mk_result(KIND_PORT, start, pos_q);
          ns           = 2'd1;
          path_begin_d = pos_q;
          mode_d       = MODE_DONE;
        end else if (char_q == CHAR_AT) begin
          // What looked like host:port was in fact user:password.
          step_r[0] = mk_result(KIND_USER, host_begin_q, host_finish_q);
          step_r[1] = mk_result(KIND_PASS, start, pos_q);
          ns        = 2'd2;
          mode_d    = MODE_HOST;
          mark_d    = pos_q;
        end
      end
      default: begin
      end
    endcase

    pos_d = sat_inc(pos_q);

    // End of the URL: close an open host or port field, then the path or a default root.
    len      = pos_d;
    start_e  = sat_inc(mark_d);
    ne       = 2'd0;
    end_r[0] = mk_result(KIND_ROOT, '0, '0);
    end_r[1] = mk_result(KIND_ROOT, '0, '0);
    if (end_q) begin
      if (mode_d == MODE_DONE) begin
        end_r[0] = mk_result(KIND_PATH, path_begin_d, len);
        ne       = 2'd1;
      end else if (mode_d == MODE_HOST) begin
        end_r[0] = mk_result(KIND_HOST, start_e, len);
        ne       = 2'd2;
      end else if (mode_d == MODE_PORT) begin
        end_r[0] = mk_result(KIND_PORT, start_e, len);
        ne       = 2'd2;
      end else begin
        ne       = 2'd1;
      end
      // Every URL starts afresh at position zero.
      mode_d        = MODE_BEGIN;
      pos_d         = '0;
      mark_d        = '0;
      host_begin_d  = '0;
      host_finish_d = '0;
      path_begin_d  = '0;
    end

    // Pack step results ahead of end results.
    res_new[0] = (ns != 2'd0) ? step_r[0] : end_r[0];
    res_new[1] = (ns == 2'd2) ? step_r[1] : ((ns == 2'd1) ? end_r[0] : end_r[1]);
    res_new[2] = (ns == 2'd2) ? end_r[0] : end_r[1];
    res_new[3] = end_r[1];
    cnt_new    = CntW'(ns) + CntW'(ne);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_BEGIN;
      pos_q         <= '0;
      mark_q        <= '0;
      host_begin_q  <= '0;
      host_finish_q <= '0;
      path_begin_q  <= '0;
      cnt_q         <= '0;
    end else begin
      if (proc) begin
        mode_q        <= mode_d;
        pos_q         <= pos_d;
        mark_q        <= mark_d;
        host_begin_q  <= host_begin_d;
        host_finish_q <= host_finish_d;
        path_begin_q  <= path_begin_d;
        cnt_q         <= cnt_new;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Bundle payload: load a whole bundle, or shift one place per result taken.
  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_q[i] <= res_new[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.field_kind = res_q[0].kind;
  assign out_o.first_pos  = res_q[0].first;
  assign out_o.end_pos    = res_q[0].last_pos;
  assign out_o.run_last   = (cnt_q == CntW'(1));

  // Checks.
  `UFS_ASSERT_NOW(a_pos_in_range, 1'b1, pos_q <= MaxPos)
  `UFS_ASSERT_NEXT(a_restart_after_end, proc && end_q, (pos_q == '0) && (mode_q == MODE_BEGIN))
  `UFS_ASSERT_NOW(a_range_ordered, out_o.valid, res_q[0].first <= res_q[0].last_pos)
  `UFS_ASSERT_NOW(a_root_is_empty, out_o.valid && (res_q[0].kind == KIND_ROOT),
                  (res_q[0].first == '0) && (res_q[0].last_pos == '0))

endmodule

`default_nettype wire
